[sv/bsfr_pkg.sv]
// Package for the byte stuffing frame receiver.
// Holds receiver mode codes, register indexes, reset values and the job record.
// Depends on nothing.
package bsfr_pkg;

   localparam int FRAME_DEPTH_DEFAULT = 64;
   localparam int COUNT_W = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int LENGTH_W = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_FLAG_VALUE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE_VALUE = 2'd1;

   localparam logic [7:0] FLAG_RESET = 8'd126;
   localparam logic [7:0] ESCAPE_RESET = 8'd125;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_DATA = 2'd1,
      MODE_ESC = 2'd2
   } rx_mode_type;

   typedef struct packed {
      logic valid;
      logic [COUNT_W-1:0] length;
   } job_type;

endpackage

[sv/bsfr_store.sv]
// Frame store: one write port and one registered read port.
// Depends on bsfr_pkg.
module bsfr_store import bsfr_pkg::*; #(
   parameter int FRAME_DEPTH = FRAME_DEPTH_DEFAULT,
   parameter int ADDR_W = $clog2(FRAME_DEPTH)
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0] wr_data,
   input  logic rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0] rd_data
);

   logic [7:0] mem [FRAME_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/bsfr_front.sv]
// Front end: accepts link bytes, runs the receiver mode machine and fills the store.
// Depends on bsfr_pkg.
module bsfr_front import bsfr_pkg::*; #(
   parameter int FRAME_DEPTH = FRAME_DEPTH_DEFAULT,
   parameter int ADDR_W = $clog2(FRAME_DEPTH)
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0] csr_data,
   input  logic req_push,
   input  logic [7:0] req_rx_byte,
   output logic req_full,
   input  logic back_busy,
   output logic wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [7:0] wr_data,
   output job_type job
);

   rx_mode_type mode_ff, mode_in;
   logic [COUNT_W-1:0] fill_ff, fill_in;
   logic [7:0] flag_ff, escape_ff;
   logic accept;
   logic store;

   assign req_full = back_busy;
   assign accept = req_push && !back_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= FLAG_RESET;
         escape_ff <= ESCAPE_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_FLAG_VALUE) begin
            flag_ff <= csr_data;
         end else if (csr_index == CSR_ESCAPE_VALUE) begin
            escape_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         fill_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         fill_ff <= fill_in;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      fill_in = fill_ff;
      store = 1'b0;
      job.valid = 1'b0;
      job.length = fill_ff;
      if (accept) begin
         case (mode_ff)
            MODE_DATA: begin
               if (req_rx_byte == escape_ff) begin
                  mode_in = MODE_ESC;
               end else if (req_rx_byte == flag_ff) begin
                  if (fill_ff != '0) begin
                     job.valid = 1'b1;
                     fill_in = '0;
                     mode_in = MODE_IDLE;
                  end
               end else begin
                  store = 1'b1;
               end
            end
            MODE_ESC: begin
               if (req_rx_byte == flag_ff || req_rx_byte == escape_ff) begin
                  store = 1'b1;
                  mode_in = MODE_DATA;
               end else begin
                  fill_in = '0;
                  mode_in = MODE_IDLE;
               end
            end
            default: begin
               mode_in = (req_rx_byte == flag_ff) ? MODE_DATA : MODE_IDLE;
            end
         endcase
      end
      wr_en = store && (fill_ff < COUNT_W'(FRAME_DEPTH));
      if (wr_en) begin
         fill_in = fill_ff + COUNT_W'(1);
      end
   end

   assign wr_addr = fill_ff[ADDR_W-1:0];
   assign wr_data = req_rx_byte;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= COUNT_W'(FRAME_DEPTH))
      else $error("fill count beyond store depth");

endmodule

[sv/bsfr_back.sv]
// Back end: holds one frame job, reads the store out and queues results for transfer.
// Depends on bsfr_pkg.
module bsfr_back import bsfr_pkg::*; #(
   parameter int FRAME_DEPTH = FRAME_DEPTH_DEFAULT,
   parameter int ADDR_W = $clog2(FRAME_DEPTH)
) (
   input  logic clock,
   input  logic reset,
   input  job_type job,
   output logic busy,
   output logic rd_en,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [7:0] rd_data,
   input  logic rsp_pop,
   output logic rsp_empty,
   output logic [7:0] rsp_frame_byte,
   output logic rsp_frame_last,
   output logic [LENGTH_W-1:0] rsp_frame_length
);

   logic busy_ff;
   logic [COUNT_W-1:0] len_ff;
   logic [COUNT_W-1:0] idx_ff;
   logic inflight_ff;
   logic inflight_last_ff;
   logic [7:0] q_byte_ff [2];
   logic q_last_ff [2];
   logic [LENGTH_W-1:0] q_len_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic [1:0] occupancy;
   logic take;
   logic issue;
   logic issue_last;

   assign take = rsp_pop && (count_ff != 2'd0);
   assign occupancy = count_ff + {1'b0, inflight_ff};
   assign issue = busy_ff && ((occupancy < 2'd2) || take);
   assign issue_last = (idx_ff + COUNT_W'(1)) == len_ff;

   assign busy = busy_ff;
   assign rd_en = issue;
   assign rd_addr = idx_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         inflight_ff <= 1'b0;
      end else begin
         inflight_ff <= issue;
         if (job.valid) begin
            busy_ff <= 1'b1;
         end else if (issue && issue_last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job.valid) begin
         len_ff <= job.length;
         idx_ff <= '0;
      end else if (issue) begin
         idx_ff <= idx_ff + COUNT_W'(1);
      end
      if (issue) begin
         inflight_last_ff <= issue_last;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (inflight_ff && !take) begin
         count_in = count_ff + 2'd1;
      end else if (!inflight_ff && take) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (inflight_ff) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (take) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (inflight_ff) begin
         q_byte_ff[wr_ptr_ff] <= rd_data;
         q_last_ff[wr_ptr_ff] <= inflight_last_ff;
         q_len_ff[wr_ptr_ff] <= LENGTH_W'(len_ff);
      end
   end

   assign rsp_empty = (count_ff == 2'd0);
   assign rsp_frame_byte = q_byte_ff[rd_ptr_ff];
   assign rsp_frame_last = q_last_ff[rd_ptr_ff];
   assign rsp_frame_length = q_len_ff[rd_ptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      occupancy <= 2'd2)
      else $error("result queue overrun");

   a_job_when_idle: assert property (@(posedge clock) disable iff (reset)
      job.valid |-> !busy_ff)
      else $error("frame job arrived while a frame is still being read out");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      issue |-> (idx_ff < len_ff))
      else $error("store read beyond the frame length");

endmodule

[sv/byte_stuffing_frame_receiver_top.sv]
// Top level of the byte stuffing frame receiver.
// Depends on bsfr_pkg, bsfr_front, bsfr_store and bsfr_back.
//
// Link bytes enter on req_rx_byte; a transfer takes place when req_push is high
// and req_full is low. Each completed frame leaves as one result per stored
// byte on rsp_frame_byte, with rsp_frame_last on the final byte and
// rsp_frame_length on every byte; a result transfer takes place when rsp_pop is
// high and rsp_empty is low. Registers are written through csr_write, csr_index
// and csr_data; the user must write them only while the block is idle, which
// the block itself does not enforce. Outside a frame readout one byte is taken
// every cycle. The closing flag hands the frame to the read-out side, and
// req_full stays high until the last stored byte has been read from the store.
// After the closing flag the first result passes the busy register of the
// read-out side, the registered read port and the result queue; results then
// follow one per cycle while they are taken, set by the single store read port.
// Synchronous reset returns the receiver to idle with an empty store and an
// empty result queue, and restores the register defaults. When the receiver
// stops taking results, the read-out pauses and input stays blocked.
module byte_stuffing_frame_receiver_top import bsfr_pkg::*; #(
   parameter int FRAME_DEPTH = FRAME_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0] csr_data,
   input  logic req_push,
   input  logic [7:0] req_rx_byte,
   output logic req_full,
   input  logic rsp_pop,
   output logic rsp_empty,
   output logic [7:0] rsp_frame_byte,
   output logic rsp_frame_last,
   output logic [LENGTH_W-1:0] rsp_frame_length
);

   localparam int ADDR_W = $clog2(FRAME_DEPTH);

   job_type job;
   logic busy;
   logic wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0] wr_data;
   logic rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0] rd_data;

   bsfr_front #(
      .FRAME_DEPTH(FRAME_DEPTH),
      .ADDR_W(ADDR_W)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_push(req_push),
      .req_rx_byte(req_rx_byte),
      .req_full(req_full),
      .back_busy(busy),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .job(job)
   );

   bsfr_store #(
      .FRAME_DEPTH(FRAME_DEPTH),
      .ADDR_W(ADDR_W)
   ) u_store (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   bsfr_back #(
      .FRAME_DEPTH(FRAME_DEPTH),
      .ADDR_W(ADDR_W)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .job(job),
      .busy(busy),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .rsp_pop(rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_frame_last(rsp_frame_last),
      .rsp_frame_length(rsp_frame_length)
   );

endmodule

[bench/byte_stuffing_frame_receiver_top_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for byte_stuffing_frame_receiver_top: link bytes in, unstuffed
// frame bytes out, checked against a predictor of the deframer kept in a scoreboard class.
// Depends on bsfr_pkg and the RTL of the frame receiver.
module byte_stuffing_frame_receiver_top_test;
   import bsfr_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 100000;

   typedef struct packed {
      logic [7:0] data;
      logic last;
      logic [LENGTH_W-1:0] length;
   } frame_beat_type;

   class unstuffed_byte_board;
      logic [7:0] flag_value = FLAG_RESET;
      logic [7:0] escape_value = ESCAPE_RESET;
      rx_mode_type mode = MODE_IDLE;
      logic [7:0] frame_bytes [FRAME_DEPTH_DEFAULT];
      int unsigned fill = 0;
      frame_beat_type expected_beats [$];
      int errors = 0;

      function void set_register(logic [CSR_INDEX_W-1:0] index, logic [7:0] value);
         if (index == CSR_FLAG_VALUE)
            flag_value = value;
         else if (index == CSR_ESCAPE_VALUE)
            escape_value = value;
      endfunction

      function void keep_byte(logic [7:0] value);
         if (fill < FRAME_DEPTH_DEFAULT) begin
            frame_bytes[fill] = value;
            fill++;
         end
      endfunction

      // Returns 0 when the byte leaves the receiver exactly as it was.
      function bit take_link_byte(logic [7:0] value);
         frame_beat_type beat;
         bit effective;
         effective = 1'b1;
         case (mode)
            MODE_DATA: begin
               if (value == escape_value) begin
                  mode = MODE_ESC;
               end else if (value == flag_value) begin
                  if (fill == 0) begin
                     effective = 1'b0;
                  end else begin
                     for (int i = 0; i < fill; i++) begin
                        beat.data = frame_bytes[i];
                        beat.last = (i + 1 == fill);
                        beat.length = fill[LENGTH_W-1:0];
                        expected_beats.push_back(beat);
                     end
                     fill = 0;
                     mode = MODE_IDLE;
                  end
               end else begin
                  keep_byte(value);
               end
            end
            MODE_ESC: begin
               if (value == flag_value || value == escape_value) begin
                  keep_byte(value);
                  mode = MODE_DATA;
               end else begin
                  fill = 0;
                  mode = MODE_IDLE;
               end
            end
            default: begin
               if (value == flag_value)
                  mode = MODE_DATA;
               else
                  effective = 1'b0;
            end
         endcase
         return effective;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      task report_mismatch(string text);
         $display("MISMATCH at %0t: %s", $realtime, text);
         errors++;
      endtask

      task check_frame_byte(logic [7:0] data, logic last, logic [LENGTH_W-1:0] length);
         frame_beat_type want;
         if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("frame byte %h with no frame pending", data));
            return;
         end
         want = expected_beats.pop_front();
         if (data !== want.data)
            report_mismatch($sformatf("frame_byte %h, expected %h", data, want.data));
         if (last !== want.last)
            report_mismatch($sformatf("frame_last %b, expected %b", last, want.last));
         if (length !== want.length)
            report_mismatch($sformatf("frame_length %0d, expected %0d", length, want.length));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [7:0] csr_data;
   logic req_push;
   logic [7:0] req_rx_byte;
   logic req_full;
   logic rsp_pop;
   logic rsp_empty;
   logic [7:0] rsp_frame_byte;
   logic rsp_frame_last;
   logic [LENGTH_W-1:0] rsp_frame_length;

   unstuffed_byte_board board;
   int tx_calm = 0;
   int rx_calm = 0;
   int busy_items = 0;
   int cycle_count = 0;
   bit hold_off_request = 1'b0;

   logic [7:0] directed_bytes [24] = '{
      8'h00, 8'h7D, 8'h7E, 8'h7E, 8'h00, 8'hFF, 8'h7D, 8'h7E, 8'h7D, 8'h7D, 8'h80, 8'h7F,
      8'h7E, 8'h7E, 8'h01, 8'h7D, 8'h33, 8'h7E, 8'h7D, 8'h7E, 8'h7E, 8'h7E, 8'h5A, 8'h7E
   };

   byte_stuffing_frame_receiver_top #(
      .FRAME_DEPTH(FRAME_DEPTH_DEFAULT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_push(req_push),
      .req_rx_byte(req_rx_byte),
      .req_full(req_full),
      .rsp_pop(rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_frame_last(rsp_frame_last),
      .rsp_frame_length(rsp_frame_length)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         board.check_frame_byte(rsp_frame_byte, rsp_frame_last, rsp_frame_length);
   end

   // Occasional stretches with no idling at all, otherwise a randomly drawn idle gap.
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 6);
   endfunction

   function automatic logic [7:0] pick_payload_byte();
      case ($urandom_range(0, 7))
         0: return board.flag_value;
         1: return board.escape_value;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      int gap;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_pop <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
         end
         gap = draw_gap(rx_calm);
         if (gap != 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   task automatic send_link_byte(input logic [7:0] value);
      int gap;
      gap = draw_gap(tx_calm);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (req_full);
      if (board.take_link_byte(value))
         busy_items++;
      @(negedge clock);
   endtask

   task automatic send_data_byte(input logic [7:0] value);
      if (value == board.flag_value || value == board.escape_value)
         send_link_byte(board.escape_value);
      send_link_byte(value);
   endtask

   task automatic send_frame(input int length);
      send_link_byte(board.flag_value);
      repeat (length) send_data_byte(pick_payload_byte());
      send_link_byte(board.flag_value);
   endtask

   task automatic send_random_frame();
      int kind;
      logic [7:0] value;
      kind = $urandom_range(0, 29);
      if (kind == 0) begin
         repeat ($urandom_range(1, 3)) send_link_byte(8'($urandom_range(0, 255)));
      end else if (kind == 1) begin
         send_link_byte(board.flag_value);
         repeat ($urandom_range(0, 4)) send_data_byte(pick_payload_byte());
         send_link_byte(board.escape_value);
         do value = 8'($urandom_range(0, 255));
         while (value == board.flag_value || value == board.escape_value);
         send_link_byte(value);
      end else if (kind == 2) begin
         send_link_byte(board.flag_value);
         send_frame($urandom_range(1, 12));
      end else if (kind == 3) begin
         send_frame($urandom_range(FRAME_DEPTH_DEFAULT + 1, FRAME_DEPTH_DEFAULT + 8));
      end else begin
         send_frame($urandom_range(1, 12));
      end
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index, input logic [7:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      board.set_register(index, value);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input logic [7:0] flag_setting, input logic [7:0] escape_setting,
                            input int budget, input int opening_length, input bit with_hold);
      drain_results();
      write_register(CSR_FLAG_VALUE, flag_setting);
      write_register(CSR_ESCAPE_VALUE, escape_setting);
      write_register(CSR_SPARE_A, 8'($urandom_range(0, 255)));
      write_register(CSR_SPARE_B, 8'($urandom_range(0, 255)));
      busy_items = 0;
      if (with_hold)
         hold_off_request = 1'b1;
      if (opening_length != 0)
         send_frame(opening_length);
      while (busy_items < budget) send_random_frame();
   endtask

   initial begin
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_FLAG_VALUE;
      csr_data = 8'h00;
      req_push = 1'b0;
      req_rx_byte = 8'h00;
      rsp_pop = 1'b0;
      board = new();
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed_bytes[i]) send_link_byte(directed_bytes[i]);
      run_phase(8'h00, 8'hFF, 80, 0, 1'b0);
      run_phase(8'hFF, 8'h00, 80, 40, 1'b1);
      run_phase(8'h42, 8'h42, 40, 0, 1'b0);
      repeat (4) run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 50, 0, 1'b0);
      run_phase(FLAG_RESET, ESCAPE_RESET, 80, FRAME_DEPTH_DEFAULT + 6, 1'b0);
      drain_results();
      if (board.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
